/* rtl/psc_pkg.sv */
// Shared types, constants and helper functions for the page slot cache.
// Used by the top level, the scan datapath and both checkers.
package psc_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int FILE_W     = 16;
  localparam int OFS_W      = 48;
  localparam int TAG_W      = FILE_W + OFS_W;
  localparam int AGE_W      = 16;
  localparam int SLOT_FLD_W = 4;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = STATUS_W;

  localparam logic [AGE_W-1:0] AGE_MAX   = 16'hFFFF;
  localparam logic [AGE_W-1:0] AGE_FRESH = (AGE_MAX >> 1) + (AGE_MAX >> 2);

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_NEW    = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_LAST_HIT = 3'd0,
    STAT_SCAN_HIT = 3'd1,
    STAT_FILL     = 3'd2,
    STAT_REPLACE  = 3'd3,
    STAT_DUP      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LH_CHK,
    FSM_SCAN,
    FSM_FIN
  } fsm_e;

  // control from the sequencer to the scan datapath
  typedef struct packed {
    logic              start;
    logic              vld;
    mode_e             mode;
    logic [SLOT_W-1:0] idx;
  } scan_ctl_t;

  // scan outcome
  typedef struct packed {
    logic              found;
    logic              dup;
    logic [SLOT_W-1:0] hit;
    logic [SLOT_W-1:0] victim;
    logic [TAG_W-1:0]  vic_tag;
  } scan_res_t;

  // AGE_FRESH + 16385*a/65535; x/65535 = (x>>16) plus one correction step
  function automatic logic [AGE_W-1:0] age_boost(input logic [AGE_W-1:0] a);
    logic [30:0] x;
    logic [14:0] q0;
    logic [16:0] r;
    logic [14:0] q;
    x  = 31'({a, 14'b0}) + 31'(a);
    q0 = x[30:16];
    r  = 17'(x[15:0]) + 17'(q0);
    q  = q0 + ((r >= 17'(AGE_MAX)) ? 15'd1 : 15'd0);
    return AGE_FRESH + 16'(q);
  endfunction

  function automatic logic [SLOT_FLD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOT_FLD_W-1:0] w;
    w = {{SLOT_FLD_W{1'b0}}, idx};
    return w[SLOT_FLD_W-1:0];
  endfunction

endpackage

/* rtl/page_slot_cache_aging_replacement.sv */
// Top level of the page slot cache with aging-counter replacement.
// Depends on psc_pkg, psc_ram and psc_scan.
//
// Channel  | Dir | Handshake              | Payload (low bit up)
// ---------+-----+------------------------+------------------------------------------
// request  | in  | s_axis_tvalid/tready   | tuser: mode; tdata: file_handle, page_offset
// result   | out | m_axis_tvalid/tready   | tuser: status; tdata: slot, evicted,
//          |     |                        |   evicted_file, evicted_offset, 3 zero bits
//
// One word at a time. Last-hit match: IDLE, LH_CHK, then FIN loads the result register.
// Scan (lookup miss on last hit, or new page): SCAN reads one slot per cycle from the tag
// and age memories and, for a lookup, writes the updated age back in the cycle after the
// read, then FIN loads the result register.
// Reset clears fill count, last-hit and control; memories stay undefined, only
// slots below fill count are read, so no clearing pass is needed.
// A new request is taken while a finished result still waits on m_axis_tready.
module page_slot_cache_aging_replacement (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [psc_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // file_handle, page_offset
  input  logic [0:0]                     s_axis_tuser,   // mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [psc_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // slot, evicted, evicted_file,
                                                         // evicted_offset, zero pad
  output logic [psc_pkg::OUT_USER_W-1:0] m_axis_tuser    // status
);

  localparam int SW = psc_pkg::SLOT_W;
  localparam int CW = psc_pkg::CNT_W;

  psc_pkg::fsm_e              state_q, state_d;
  psc_pkg::mode_e             mode_q;
  logic [psc_pkg::TAG_W-1:0]  req_tag_q;
  logic [CW-1:0]              fill_q;
  logic                       lh_valid_q;
  logic [SW-1:0]              lh_slot_q;
  logic [CW-1:0]              cnt_q;
  logic                       pv_q;
  logic [SW-1:0]              pidx_q;
  logic                       lh_hit_q;

  // result register
  logic                       m_valid_q;
  psc_pkg::status_e           out_status_q;
  logic [psc_pkg::SLOT_FLD_W-1:0] out_slot_q;
  logic                       out_ev_q;
  logic [psc_pkg::TAG_W-1:0]  out_tag_q;

  // memory ports
  logic [SW-1:0]              raddr;
  logic [psc_pkg::TAG_W-1:0]  rd_tag;
  logic [psc_pkg::AGE_W-1:0]  rd_age;
  logic                       tag_we, age_we;
  logic [SW-1:0]              age_waddr;
  logic [psc_pkg::AGE_W-1:0]  age_wdata;

  psc_pkg::scan_ctl_t         scan_ctl;
  psc_pkg::scan_res_t         scan_res;
  logic                       scan_age_we;
  logic [psc_pkg::AGE_W-1:0]  scan_age;

  logic                       accept, out_free, fin_fire, lh_try, lh_match, scan_done;
  logic                       full, place, upd_lh;
  logic [SW-1:0]              res_slot;
  psc_pkg::status_e           res_status;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign full      = (fill_q == CW'(psc_pkg::SLOTS));
  assign lh_try    = (psc_pkg::mode_e'(s_axis_tuser[0]) == psc_pkg::MODE_LOOKUP) &&
                     lh_valid_q && (CW'(lh_slot_q) < fill_q);
  assign lh_match  = (rd_tag == req_tag_q);
  assign scan_done = !pv_q && (cnt_q >= fill_q);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      psc_pkg::FSM_IDLE: begin
        if (accept) begin
          state_d = lh_try ? psc_pkg::FSM_LH_CHK : psc_pkg::FSM_SCAN;
        end
      end
      psc_pkg::FSM_LH_CHK: begin
        state_d = lh_match ? psc_pkg::FSM_FIN : psc_pkg::FSM_SCAN;
      end
      psc_pkg::FSM_SCAN: begin
        if (scan_done) begin
          state_d = psc_pkg::FSM_FIN;
        end
      end
      psc_pkg::FSM_FIN: begin
        if (out_free) begin
          state_d = psc_pkg::FSM_IDLE;
        end
      end
      default: state_d = psc_pkg::FSM_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    s_axis_tready = 1'b0;
    fin_fire      = 1'b0;
    raddr         = lh_slot_q;
    case (state_q)
      psc_pkg::FSM_IDLE: s_axis_tready = 1'b1;
      psc_pkg::FSM_SCAN: raddr = cnt_q[SW-1:0];
      psc_pkg::FSM_FIN:  fin_fire = out_free;
      default: ;
    endcase
  end

  // decision on the finished last-hit check or scan
  always_comb begin
    place      = 1'b0;
    upd_lh     = 1'b0;
    res_slot   = '0;
    res_status = psc_pkg::STAT_DUP;
    if (lh_hit_q) begin
      res_status = psc_pkg::STAT_LAST_HIT;
      res_slot   = lh_slot_q;
    end else if (scan_res.dup) begin
      res_status = psc_pkg::STAT_DUP;
    end else if (scan_res.found) begin
      res_status = psc_pkg::STAT_SCAN_HIT;
      res_slot   = scan_res.hit;
      upd_lh     = 1'b1;
    end else begin
      place  = 1'b1;
      upd_lh = 1'b1;
      if (full) begin
        res_status = psc_pkg::STAT_REPLACE;
        res_slot   = scan_res.victim;
      end else begin
        res_status = psc_pkg::STAT_FILL;
        res_slot   = fill_q[SW-1:0];
      end
    end
  end

  assign scan_ctl = '{start: accept, vld: pv_q, mode: mode_q, idx: pidx_q};

  // age memory is written by the scan or by a placement, never both at once
  assign tag_we    = fin_fire && place;
  assign age_we    = scan_age_we || tag_we;
  assign age_waddr = tag_we ? res_slot : pidx_q;
  assign age_wdata = tag_we ? psc_pkg::AGE_FRESH : scan_age;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= psc_pkg::FSM_IDLE;
      fill_q     <= '0;
      lh_valid_q <= 1'b0;
      lh_slot_q  <= '0;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      lh_hit_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q    <= '0;
        pv_q     <= 1'b0;
        lh_hit_q <= 1'b0;
      end
      if (state_q == psc_pkg::FSM_LH_CHK) begin
        lh_hit_q <= lh_match;
      end
      if (state_q == psc_pkg::FSM_SCAN) begin
        if (cnt_q < fill_q) begin
          cnt_q <= cnt_q + 1'b1;
          pv_q  <= 1'b1;
        end else begin
          pv_q <= 1'b0;
        end
      end
      if (fin_fire) begin
        if (place && !full) begin
          fill_q <= fill_q + 1'b1;
        end
        if (upd_lh) begin
          lh_valid_q <= 1'b1;
          lh_slot_q  <= res_slot;
        end
      end
      if (fin_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= psc_pkg::mode_e'(s_axis_tuser[0]);
      req_tag_q <= s_axis_tdata;
    end
    if (state_q == psc_pkg::FSM_SCAN) begin
      pidx_q <= cnt_q[SW-1:0];
    end
    if (fin_fire) begin
      out_status_q <= res_status;
      out_slot_q   <= psc_pkg::slot_field(res_slot);
      out_ev_q     <= place && full;
      out_tag_q    <= (place && full) ? scan_res.vic_tag : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_tag_q, out_ev_q, out_slot_q};

  // ---------------- memories and scan unit ----------------
  psc_ram #(
    .WIDTH(psc_pkg::TAG_W),
    .DEPTH(psc_pkg::SLOTS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(res_slot),
    .wdata_i(req_tag_q),
    .raddr_i(raddr),
    .rdata_o(rd_tag)
  );

  psc_ram #(
    .WIDTH(psc_pkg::AGE_W),
    .DEPTH(psc_pkg::SLOTS)
  ) u_age_ram (
    .clk_i  (clk_i),
    .we_i   (age_we),
    .waddr_i(age_waddr),
    .wdata_i(age_wdata),
    .raddr_i(raddr),
    .rdata_o(rd_age)
  );

  psc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .req_tag_i  (req_tag_q),
    .rd_tag_i   (rd_tag),
    .rd_age_i   (rd_age),
    .age_we_o   (scan_age_we),
    .age_wdata_o(scan_age),
    .res_o      (scan_res)
  );

endmodule

/* rtl/psc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/psc_scan.sv */
// Per-slot scan datapath: tag match, age update and victim tracking.
// Depends on psc_pkg.
module psc_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  psc_pkg::scan_ctl_t        ctl_i,
  input  logic [psc_pkg::TAG_W-1:0] req_tag_i,
  input  logic [psc_pkg::TAG_W-1:0] rd_tag_i,
  input  logic [psc_pkg::AGE_W-1:0] rd_age_i,
  output logic                      age_we_o,
  output logic [psc_pkg::AGE_W-1:0] age_wdata_o,
  output psc_pkg::scan_res_t        res_o
);

  logic                        found_q, dup_q;
  logic [psc_pkg::SLOT_W-1:0]  hit_q, victim_q;
  logic [psc_pkg::AGE_W-1:0]   vic_age_q;
  logic [psc_pkg::TAG_W-1:0]   vic_tag_q;
  logic                        match, take, lookup;
  logic [psc_pkg::AGE_W-1:0]   new_age;

  always_comb begin
    lookup = (ctl_i.mode == psc_pkg::MODE_LOOKUP);
    match  = (rd_tag_i == req_tag_i);
    if (match) begin
      new_age = psc_pkg::age_boost(rd_age_i);
    end else if (rd_age_i != '0) begin
      new_age = rd_age_i - 1'b1;
    end else begin
      new_age = '0;
    end
    // slot 0 seeds the victim; later slots compare their old age against
    // the victim's stored age, which in lookup mode is its updated age
    take        = (ctl_i.idx == '0) || (rd_age_i < vic_age_q);
    age_we_o    = ctl_i.vld && lookup;
    age_wdata_o = new_age;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      dup_q   <= 1'b0;
    end else if (ctl_i.start) begin
      found_q <= 1'b0;
      dup_q   <= 1'b0;
    end else if (ctl_i.vld && match) begin
      if (lookup) begin
        found_q <= 1'b1;
      end else begin
        dup_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      if (match && lookup) begin
        hit_q <= ctl_i.idx;
      end
      if (take) begin
        victim_q  <= ctl_i.idx;
        vic_age_q <= lookup ? new_age : rd_age_i;
        vic_tag_q <= rd_tag_i;
      end
    end
  end

  assign res_o = '{found: found_q, dup: dup_q, hit: hit_q, victim: victim_q,
                   vic_tag: vic_tag_q};

endmodule

/* rtl/psc_checker.sv */
// Port-level checker for the page slot cache, bound to the top level.
// Depends on psc_pkg.
module psc_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [psc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [psc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one request at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while one is in flight");

  // eviction flag only on a replacement
  a_evict_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tuser == psc_pkg::STAT_REPLACE)))
    else $error("evicted flag does not match status");

  // no displaced page means a zero evicted tag
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> (m_axis_tdata[68:5] == '0))
    else $error("evicted tag not zero without eviction");

  // duplicate reports slot zero
  a_dup_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == psc_pkg::STAT_DUP) |-> (m_axis_tdata[3:0] == '0))
    else $error("duplicate result with nonzero slot");

endmodule

bind page_slot_cache_aging_replacement psc_port_checker u_psc_checker (.*);

/* tb/psc_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the page slot cache: tracks tags, ages and fill state,
// predicts each result word and compares it with the block's output.
// Depends on psc_pkg for widths and status and mode codes.
module psc_checker
  import psc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [IN_DATA_W-1:0]  req_data_i,   // file_handle, page_offset
  input  logic [0:0]            req_user_i,   // mode
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_DATA_W-1:0] res_data_i,   // slot, evicted, evicted_file, evicted_offset, pad
  input  logic [OUT_USER_W-1:0] res_user_i,   // status
  output int                    errors_o,
  output int                    pending_o,
  output int                    requests_o,
  output int                    replaced_o,
  output int                    dups_o
);

  typedef struct packed {
    status_e           status;
    logic [3:0]        slot;
    logic              evicted;
    logic [FILE_W-1:0] ev_file;
    logic [OFS_W-1:0]  ev_ofs;
  } cache_result_t;

  // shadow cache state
  int unsigned       fill_q;
  logic              lh_valid;
  logic [SLOT_W-1:0] lh_slot;
  logic [FILE_W-1:0] tag_f [SLOTS];
  logic [OFS_W-1:0]  tag_o [SLOTS];
  logic [AGE_W-1:0]  age_q [SLOTS];

  cache_result_t expected_q [$];
  int errors, requests, replaced, dups;

  initial begin
    errors   = 0;
    requests = 0;
    replaced = 0;
    dups     = 0;
  end

  function automatic logic [AGE_W-1:0] boosted_age(input logic [AGE_W-1:0] a);
    int unsigned prod;
    prod = (32'(AGE_MAX) - 32'(AGE_FRESH)) * 32'(a);
    return AGE_FRESH + 16'(prod / 32'(AGE_MAX));
  endfunction

  function automatic bit tag_match(input int s, input logic [FILE_W-1:0] f,
                                   input logic [OFS_W-1:0] o);
    return (tag_f[s] == f) && (tag_o[s] == o);
  endfunction

  // fill the next free slot, or overwrite the victim once full
  task automatic place_page(input logic [FILE_W-1:0] f, input logic [OFS_W-1:0] o,
                            input int victim, inout cache_result_t r);
    int s;
    if (fill_q < SLOTS) begin
      s = fill_q;
      fill_q++;
      r.status = STAT_FILL;
    end else begin
      s = victim;
      r.status  = STAT_REPLACE;
      r.evicted = 1'b1;
      r.ev_file = tag_f[s];
      r.ev_ofs  = tag_o[s];
    end
    r.slot   = 4'(s);
    tag_f[s] = f;
    tag_o[s] = o;
    age_q[s] = AGE_FRESH;
    lh_valid = 1'b1;
    lh_slot  = SLOT_W'(s);
  endtask

  task automatic predict_access(input logic m, input logic [FILE_W-1:0] f,
                                input logic [OFS_W-1:0] o, output cache_result_t r);
    int  victim;
    int  hit;
    int  n;
    bit  found;
    bit  dup;
    r      = '0;
    victim = 0;
    hit    = 0;
    found  = 1'b0;
    dup    = 1'b0;
    n      = fill_q;
    if (m == MODE_NEW) begin
      for (int i = 0; i < n; i++)
        if (tag_match(i, f, o)) dup = 1'b1;
      if (dup) begin
        r.status = STAT_DUP;
      end else begin
        // plain minimum search, ages untouched
        for (int i = 0; i < n; i++)
          if (age_q[i] < age_q[victim]) victim = i;
        place_page(f, o, victim, r);
      end
    end else if (lh_valid && (lh_slot < n) && tag_match(lh_slot, f, o)) begin
      r.status = STAT_LAST_HIT;
      r.slot   = 4'(lh_slot);
    end else begin
      // victim compare uses the pre-update age of slot i against the
      // already updated age of the current victim
      for (int i = 0; i < n; i++) begin
        if (age_q[i] < age_q[victim]) victim = i;
        if (tag_match(i, f, o)) begin
          age_q[i] = boosted_age(age_q[i]);
          found    = 1'b1;
          hit      = i;
        end else if (age_q[i] != '0) begin
          age_q[i] = age_q[i] - 1'b1;
        end
      end
      if (found) begin
        lh_valid = 1'b1;
        lh_slot  = SLOT_W'(hit);
        r.status = STAT_SCAN_HIT;
        r.slot   = 4'(hit);
      end else begin
        place_page(f, o, victim, r);
      end
    end
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    cache_result_t want;
    cache_result_t pred;
    if (!rst_ni) begin
      fill_q   = 0;
      lh_valid = 1'b0;
      lh_slot  = '0;
      expected_q.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with no request outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, res_user_i);
          check_field("slot", want.slot, res_data_i[3:0]);
          check_field("evicted", want.evicted, res_data_i[4]);
          check_field("evicted_file", want.ev_file, res_data_i[20:5]);
          check_field("evicted_offset", want.ev_ofs, res_data_i[68:21]);
          check_field("pad", 0, res_data_i[71:69]);
        end
      end
      if (req_valid_i && req_ready_i) begin
        predict_access(req_user_i[0], req_data_i[15:0], req_data_i[63:16], pred);
        expected_q.push_back(pred);
        requests++;
        if (pred.status == STAT_REPLACE) replaced++;
        if (pred.status == STAT_DUP) dups++;
      end
    end
    errors_o   <= errors;
    pending_o  <= expected_q.size();
    requests_o <= requests;
    replaced_o <= replaced;
    dups_o     <= dups;
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the page slot cache testbench: clock, reset, request stimulus and
// result back-pressure; checking lives in psc_checker. Depends on psc_pkg.
module testbench;
  import psc_pkg::*;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  s_valid = 1'b0;
  logic [IN_DATA_W-1:0]  s_data  = '0;
  logic [0:0]            s_user  = '0;
  logic                  s_ready;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [OUT_USER_W-1:0] m_user;

  int errors, pending, requests, replaced, dups;

  // when set, neither side inserts idle cycles
  bit calm = 1'b0;

  // working set of tags for the current phase
  logic [FILE_W-1:0] pool_f [$];
  logic [OFS_W-1:0]  pool_o [$];

  always #5 clk = ~clk;

  page_slot_cache_aging_replacement i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  psc_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (s_valid),
    .req_ready_i (s_ready),
    .req_data_i  (s_data),
    .req_user_i  (s_user),
    .res_valid_i (m_valid),
    .res_ready_i (m_ready),
    .res_data_i  (m_data),
    .res_user_i  (m_user),
    .errors_o    (errors),
    .pending_o   (pending),
    .requests_o  (requests),
    .replaced_o  (replaced),
    .dups_o      (dups)
  );

  // Hard stop; a correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("[page_slot_cache_aging_replacement] ERROR");
    $finish;
  end

  // Tag fields biased toward the extremes and single set bits, so every bit
  // of both fields sees both values.
  function automatic logic [FILE_W-1:0] pick_file();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'(1) << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 48'(1) << $urandom_range(0, 47);
      3:       return 48'({$urandom_range(0, 255), 12'h000});  // page aligned, low range
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // Present one request word and hold it until the block takes it.
  // valid only drops when a gap is drawn, so it never toggles within a step.
  task automatic send_word(input mode_e m, input logic [FILE_W-1:0] f,
                           input logic [OFS_W-1:0] o);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {o, f};
    s_user  <= m;
    do @(posedge clk); while (!s_ready);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (24) @(posedge clk);  // one worst-case scan plus margin
  endtask

  // One random phase: mostly hits and misses within a small working set,
  // with repeats for the last-hit path, near misses and unrelated tags.
  task automatic run_phase(input int n_words, input int pool_size, input int new_pct);
    int                roll;
    int                idx;
    int                bitpos;
    mode_e             m;
    logic [FILE_W-1:0] f, pf;
    logic [OFS_W-1:0]  o, po;
    pool_f.delete();
    pool_o.delete();
    repeat (pool_size) begin
      pool_f.push_back(pick_file());
      pool_o.push_back(pick_offset());
    end
    pf = pool_f[0];
    po = pool_o[0];
    for (int k = 0; k < n_words; k++) begin
      roll = $urandom_range(0, 99);
      idx  = $urandom_range(0, pool_size - 1);
      if (roll < 15) begin
        f = pf;
        o = po;
      end else if (roll < 85) begin
        f = pool_f[idx];
        o = pool_o[idx];
      end else if (roll < 93) begin
        // near miss: one bit off a cached tag
        bitpos = $urandom_range(0, TAG_W - 1);
        {o, f} = {pool_o[idx], pool_f[idx]} ^ (64'(1) << bitpos);
      end else begin
        f = pick_file();
        o = pick_offset();
      end
      m = ($urandom_range(0, 99) < new_pct) ? MODE_NEW : MODE_LOOKUP;
      send_word(m, f, o);
      pf = f;
      po = o;
    end
  endtask

  // Result side: a freshly drawn random stall before each word, skipped when calm is set.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty cache, extreme tags, last-hit, scan hit, duplicates,
    // then fill to capacity and force replacement on both paths.
    send_word(MODE_LOOKUP, '0, '0);            // miss on empty, fills slot 0
    send_word(MODE_LOOKUP, '0, '0);            // last-hit
    send_word(MODE_NEW, '1, '1);               // fills slot 1
    send_word(MODE_NEW, '1, '1);               // duplicate
    send_word(MODE_NEW, '0, '0);               // duplicate of an older slot
    send_word(MODE_LOOKUP, '0, '0);            // scan hit, last-hit was slot 1
    send_word(MODE_LOOKUP, '1, '1);            // scan hit
    for (int k = 0; k < 14; k++)
      send_word(MODE_NEW, 16'(k * 4099 + 1), 48'(k + 1) << (k * 3));
    send_word(MODE_LOOKUP, 16'h1234, 48'hABCD_0000_1000);  // miss when full
    send_word(MODE_NEW, 16'h4321, 48'h0000_5678_9000);     // replace minimum age
    send_word(MODE_NEW, 16'h4321, 48'h0000_5678_9000);     // duplicate of new page
    send_word(MODE_LOOKUP, 16'h4321, 48'h0000_5678_9000);  // last-hit after replace
    drain();

    // Random phases; each one drains fully before the next (sender hold-off).
    run_phase(275, 4, 10);
    drain();
    run_phase(275, 12, 25);
    drain();
    calm = 1'b1;
    run_phase(275, 20, 20);
    drain();
    calm = 1'b0;
    run_phase(275, 32, 30);
    drain();
    run_phase(275, 17, 15);
    drain();
    run_phase(275, 64, 50);
    drain();

    $display("Ran %0d requests: lookups and new pages over working sets of 4 to 64 tags,",
             requests);
    $display("%0d evictions and %0d duplicate rejects, with random stalls on both sides.",
             replaced, dups);
    if (errors == 0) begin
      $display("[page_slot_cache_aging_replacement] OK");
    end else begin
      $display("[page_slot_cache_aging_replacement] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/psc_pkg.sv
rtl/psc_ram.sv
rtl/psc_scan.sv
rtl/page_slot_cache_aging_replacement.sv
rtl/psc_checker.sv
tb/psc_checker.sv
tb/testbench.sv
